// File: sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the servo pulse generator
// Field widths, width clamp limits, request codes and the clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // Payload widths
    localparam int unsigned CHAN_ID_W  = 4;
    localparam int unsigned REQ_W      = 16;
    localparam int unsigned PULSE_W    = 11;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned PIN_W      = 4;

    // Default channel count of the top level
    localparam int unsigned CHANNEL_COUNT_DEF = 4;

    // Pulse width limits and frame reset value, in ticks
    localparam logic [PULSE_W-1:0] WIDTH_MIN   = 11'd500;
    localparam logic [PULSE_W-1:0] WIDTH_MAX   = 11'd2000;
    localparam logic [TICK_W-1:0]  FRAME_RESET = 16'd20000;
    localparam logic [TICK_W-1:0]  TICK_SAT    = 16'hFFFF;

    // Request codes
    typedef enum logic [0:0] {
        REQ_TICK      = 1'b0,
        REQ_SET_WIDTH = 1'b1
    } t_req_type;

    // Per-channel control for one transaction
    typedef struct packed {
        logic               tick;
        logic               set_we;
        logic [PULSE_W-1:0] set_width;
    } t_chan_ctrl;

    // Clamp a requested width to the legal servo range
    function automatic logic [PULSE_W-1:0] clamp_width(input logic [REQ_W-1:0] w);
        logic [PULSE_W-1:0] r;
        if (w > {5'b0, WIDTH_MAX}) begin
            r = WIDTH_MAX;
        end else if (w < {5'b0, WIDTH_MIN}) begin
            r = WIDTH_MIN;
        end else begin
            r = w[PULSE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/msp_req_if.sv
// ----------------------------------------------------------------------------
// msp_req_if: request channel
// Valid/ready channel carrying ticks and set-width commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_req_if
    import msp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [0:0]           req_type;
    logic [CHAN_ID_W-1:0] channel;
    logic [REQ_W-1:0]     width_request;

    modport source (output valid, output req_type, output channel,
                    output width_request, input ready);
    modport sink   (input valid, input req_type, input channel,
                    input width_request, output ready);
endinterface

`default_nettype wire

// File: sv/msp_res_if.sv
// ----------------------------------------------------------------------------
// msp_res_if: result channel
// Valid/ready channel carrying the pin levels after each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_res_if
    import msp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

`default_nettype wire

// File: sv/multi_channel_servo_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator_unit: RC servo pulse generator
// Per-channel servo frames driven by a one-microsecond tick stream.
// ----------------------------------------------------------------------------
// Usage:
//  - i_req carries transactions: a tick (req_type 0) advances every channel by
//    one tick; a set-width command (req_type 1) stores a width, clamped to
//    500..2000, for the addressed channel (out-of-range channel means 0). It
//    takes effect at that channel's next rising edge.
//  - o_res returns one transaction per request: the pin levels of channels
//    0..3 after that request has been applied.
//  - i_cfg_we/i_cfg_data write frame_period (reset 20000); write while idle.
//  - Results are registered before o_res.valid; one request per cycle is taken
//    unless the skid register is full, as all channels update in parallel.
//  - Reset: every channel sits low; it first rises frame_period ticks later.
//  - When o_res stalls, one further result is held in a skid register;
//    i_req.ready drops only while that register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_servo_pulse_generator_unit
    import msp_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    msp_req_if.sink                i_req,
    msp_res_if.source              o_res,
    input  wire logic              i_cfg_we,
    input  wire logic [TICK_W-1:0] i_cfg_data
);

    logic [TICK_W-1:0]        r_frame_period;
    logic [CHANNEL_COUNT-1:0] pin_next;
    logic [PIN_W-1:0]         pin_word;
    logic                     accept;
    logic                     is_set;
    logic                     chan_oob;
    logic [PULSE_W-1:0]       clamped;
    logic                     out_fire;

    logic                     r_out_valid;
    logic [PIN_W-1:0]         r_out_pins;
    logic                     r_skid_valid;
    logic [PIN_W-1:0]         r_skid_pins;

    // Request decode
    assign accept   = i_req.valid && i_req.ready;
    assign is_set   = (t_req_type'(i_req.req_type) == REQ_SET_WIDTH);
    assign chan_oob = ({1'b0, i_req.channel} >= 5'(CHANNEL_COUNT));
    assign clamped  = clamp_width(i_req.width_request);

    // Frame period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= FRAME_RESET;
        end else if (i_cfg_we) begin
            r_frame_period <= i_cfg_data;
        end
    end

    // Channel array
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
        t_chan_ctrl ctrl;
        always_comb begin
            ctrl.tick      = accept && !is_set;
            ctrl.set_we    = accept && is_set &&
                             ((!chan_oob && (i_req.channel == CHAN_ID_W'(c))) ||
                              (chan_oob && (c == 0)));
            ctrl.set_width = clamped;
        end
        msp_channel u_chan (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_frame_period (r_frame_period),
            .i_ctrl         (ctrl),
            .o_pin_next     (pin_next[c])
        );
    end

    // Only the first four channels reach the pin word
    for (genvar b = 0; b < PIN_W; b++) begin : g_pin
        if (b < CHANNEL_COUNT) begin : g_used
            assign pin_word[b] = pin_next[b];
        end else begin : g_unused
            assign pin_word[b] = 1'b0;
        end
    end

    // Output register with skid stage
    assign out_fire    = r_out_valid && o_res.ready;
    assign i_req.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out_pins   <= r_skid_pins;
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_fire) begin
                r_out_valid <= accept;
                if (accept) begin
                    r_out_pins <= pin_word;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
                r_skid_pins  <= pin_word;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pin_levels = r_out_pins;

    // Skid entry is only ever behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data with empty output register");

    // A request taken while the output stalls lands in the skid register
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !o_res.ready) |=> r_skid_valid)
        else $error("stalled transaction not parked in skid");

    // Draining the skid keeps the output occupied
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_res.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid drain lost a transaction");

endmodule

`default_nettype wire

// File: sv/msp_channel.sv
// ----------------------------------------------------------------------------
// msp_channel: state of one servo channel
// Elapsed tick counter, phase, captured and pending width; gives the pin
// level that the channel shows after the current transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_channel
    import msp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TICK_W-1:0] i_frame_period,
    input  wire t_chan_ctrl        i_ctrl,
    output logic                   o_pin_next
);

    logic [PULSE_W-1:0] r_width_setting, n_width_setting;
    logic [PULSE_W-1:0] r_captured,      n_captured;
    logic [TICK_W-1:0]  r_elapsed,       n_elapsed;
    logic               r_high,          n_high;
    logic [TICK_W-1:0]  inc_elapsed;

    // Saturating tick count
    assign inc_elapsed = (r_elapsed == TICK_SAT) ? r_elapsed : r_elapsed + 16'd1;

    // Next state: at most one phase change per tick
    always_comb begin
        n_width_setting = r_width_setting;
        n_captured      = r_captured;
        n_elapsed       = r_elapsed;
        n_high          = r_high;
        if (i_ctrl.set_we) begin
            n_width_setting = i_ctrl.set_width;
        end
        if (i_ctrl.tick) begin
            n_elapsed = inc_elapsed;
            if (r_high) begin
                if (inc_elapsed >= {5'b0, r_captured}) begin
                    n_high = 1'b0;
                end
            end else if (inc_elapsed >= i_frame_period) begin
                n_high     = 1'b1;
                n_elapsed  = '0;
                n_captured = r_width_setting;
            end
        end
    end

    // Pin level seen once this transaction is applied
    assign o_pin_next = n_high && (n_elapsed < {5'b0, n_captured});

    // State registers; reset leaves an expired high phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_setting <= WIDTH_MIN;
            r_captured      <= '0;
            r_elapsed       <= '0;
            r_high          <= 1'b1;
        end else begin
            r_width_setting <= n_width_setting;
            r_captured      <= n_captured;
            r_elapsed       <= n_elapsed;
            r_high          <= n_high;
        end
    end

    // Stored width never leaves the clamp range
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width_setting >= WIDTH_MIN) && (r_width_setting <= WIDTH_MAX))
        else $error("width setting outside clamp range");

    // A rising edge restarts the count and captures the pending width
    a_rise_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_high) |-> (r_elapsed == '0) && (r_captured == $past(r_width_setting)))
        else $error("rising edge without restart and capture");

    // Without a tick the timing state holds
    a_hold_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.tick |=> $stable(r_elapsed) && $stable(r_high) && $stable(r_captured))
        else $error("timing state moved without a tick");

    // Phase only drops on a tick
    a_fall_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_high) |-> $past(i_ctrl.tick))
        else $error("phase fell without a tick");

endmodule

`default_nettype wire
